@@ hw/rtl/assert_macros.svh @@
// assertion helpers for the translation table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock, quiet in reset
`define ASSERT_IMPL(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication, quiet in reset
`define ASSERT_NEXT(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error(msg);

`endif

@@ hw/rtl/mptt_pkg.sv @@
`default_nettype none
package mptt_pkg;
    localparam int Entries = 16;
    localparam int Buckets = 10;
    localparam int IdxW = 4;
    localparam int BktW = 4;
    localparam int RankW = 5;
    localparam int MacW = 48;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0, OP_DEL_RND = 3'd1, OP_SET_RND = 3'd2, OP_SET_BASE = 3'd3,
        OP_LOOK_RND = 3'd4, OP_LOOK_BASE = 3'd5, OP_CLEAR = 3'd6, OP_NONE = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_MISS = 2'd1, ST_FULL = 2'd2
    } status_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;      // capture the request
        logic hash_step; // one byte of the hash
        logic hash_fold; // fold hash nibbles into a small residue
        logic hash_mod;  // reduce hash to a bucket
        logic scan;      // visit one slot
        logic commit;    // apply the update
        logic adjust;    // rank fix-up on one slot
        logic finish;    // latch result
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic hash_done;
        logic scan_last;
    } sts_t;
endpackage
`default_nettype wire

@@ hw/rtl/mptt_ctrl.sv @@
`default_nettype none
module mptt_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_fire,
    input  wire logic          out_busy,
    input  wire mptt_pkg::sts_t sts,
    output mptt_pkg::cmd_t     cmd,
    output logic               idle
);
    typedef enum logic [2:0] {
        S_IDLE, S_HASH, S_FOLD, S_MOD, S_SCAN, S_COMMIT, S_ADJ, S_DONE
    } state_t;

    state_t state_reg, state_next;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_fire) state_next = S_HASH;
            S_HASH:   if (sts.hash_done) state_next = S_FOLD;
            S_FOLD:   state_next = S_MOD;
            S_MOD:    state_next = S_SCAN;
            S_SCAN:   if (sts.scan_last) state_next = S_COMMIT;
            S_COMMIT: state_next = S_ADJ;
            S_ADJ:    if (sts.scan_last) state_next = S_DONE;
            S_DONE:   if (!out_busy) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // commands
    always_comb begin
        cmd = '0;
        cmd.load      = in_fire;
        cmd.hash_step = (state_reg == S_HASH);
        cmd.hash_fold = (state_reg == S_FOLD);
        cmd.hash_mod  = (state_reg == S_MOD);
        cmd.scan      = (state_reg == S_SCAN);
        cmd.commit    = (state_reg == S_COMMIT);
        cmd.adjust    = (state_reg == S_ADJ);
        cmd.finish    = (state_reg == S_DONE) && !out_busy;
    end

    assign idle = (state_reg == S_IDLE);
endmodule
`default_nettype wire

@@ hw/rtl/mptt_dp.sv @@
`default_nettype none
module mptt_dp (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire mptt_pkg::cmd_t                cmd,
    input  wire logic [2:0]                    in_op,
    input  wire logic [mptt_pkg::MacW-1:0]     in_base,
    input  wire logic [mptt_pkg::MacW-1:0]     in_rnd,
    output mptt_pkg::sts_t                     sts,
    output logic [1:0]                         res_status,
    output logic [mptt_pkg::MacW-1:0]          res_base,
    output logic [mptt_pkg::MacW-1:0]          res_rnd
);
    localparam int E = mptt_pkg::Entries;
    localparam int IW = mptt_pkg::IdxW;
    localparam int MW = mptt_pkg::MacW;
    localparam int BW = mptt_pkg::BktW;
    localparam int RW = mptt_pkg::RankW;

    // slot storage
    logic [E-1:0]  valid_reg;
    logic [MW-1:0] sbase_mem [E];
    logic [MW-1:0] srnd_mem  [E];
    logic [BW-1:0] sbkt_mem  [E];
    logic [RW-1:0] srank_mem [E];

    // request
    mptt_pkg::op_t  op_reg;
    logic [MW-1:0]  base_reg, rnd_reg;
    logic [31:0]    hash_reg;
    logic [2:0]     byte_reg;
    logic [9:0]     fold_reg;
    logic [BW-1:0]  bkt_reg;
    logic [IW-1:0]  idx_reg;
    logic           hit_reg, free_hit_reg;
    logic [IW-1:0]  sel_reg, free_reg;
    logic [BW-1:0]  sel_bkt_reg;
    logic [RW-1:0]  sel_rank_reg;
    logic           ins_ok_reg;

    // hash byte, most significant byte first
    logic [7:0]  hbyte;
    logic [31:0] hash_next;
    assign hbyte = rnd_reg[8*byte_reg +: 8];
    assign hash_next = (hash_reg << 5) + {24'd0, hbyte};

    // bucket for ten buckets: every nibble above the lowest weighs 6 mod 10,
    // so the hash folds to a residue below 646, then a reciprocal multiply
    logic [6:0]  nib_sum;
    logic [9:0]  fold_next;
    logic [17:0] mod_prod;
    logic [6:0]  mod_q;
    logic [9:0]  mod_rem;
    assign nib_sum = {3'd0, hash_reg[7:4]} + {3'd0, hash_reg[11:8]} +
                     {3'd0, hash_reg[15:12]} + {3'd0, hash_reg[19:16]} +
                     {3'd0, hash_reg[23:20]} + {3'd0, hash_reg[27:24]} +
                     {3'd0, hash_reg[31:28]};
    assign fold_next = {6'd0, hash_reg[3:0]} + {1'b0, nib_sum, 2'b00} +
                       {2'b00, nib_sum, 1'b0};
    assign mod_prod = {8'd0, fold_reg} * 18'd205;
    assign mod_q = mod_prod[17:11];
    assign mod_rem = fold_reg - ({mod_q, 3'b000} + {2'b00, mod_q, 1'b0});

    // slot under scan
    logic        cur_v, key_match, better;
    logic [MW-1:0] cur_key, want_key;
    logic        by_base;
    assign cur_v = valid_reg[idx_reg];
    assign by_base = (op_reg == mptt_pkg::OP_SET_RND) || (op_reg == mptt_pkg::OP_LOOK_BASE);
    assign cur_key = by_base ? sbase_mem[idx_reg] : srnd_mem[idx_reg];
    assign want_key = by_base ? base_reg : rnd_reg;
    always_comb begin
        key_match = cur_v && (cur_key == want_key);
        if (op_reg == mptt_pkg::OP_DEL_RND) begin
            key_match = key_match && (sbkt_mem[idx_reg] == bkt_reg);
        end
        better = !hit_reg || (sbkt_mem[idx_reg] < sel_bkt_reg) ||
                 ((sbkt_mem[idx_reg] == sel_bkt_reg) && (srank_mem[idx_reg] < sel_rank_reg));
    end

    assign sts.hash_done = (byte_reg == 3'd0);
    assign sts.scan_last = (idx_reg == IW'(E - 1));

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (cmd.commit) begin
                unique case (op_reg)
                    mptt_pkg::OP_INSERT: if (free_hit_reg) valid_reg[free_reg] <= 1'b1;
                    mptt_pkg::OP_DEL_RND: if (hit_reg) valid_reg[sel_reg] <= 1'b0;
                    mptt_pkg::OP_CLEAR: valid_reg <= '0;
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= mptt_pkg::op_t'(in_op);
            base_reg <= in_base;
            rnd_reg  <= in_rnd;
            hash_reg <= '0;
            byte_reg <= 3'd5;
            hit_reg  <= 1'b0;
            free_hit_reg <= 1'b0;
            idx_reg  <= '0;
        end
        if (cmd.hash_step) begin
            hash_reg <= hash_next;
            if (byte_reg != 3'd0) byte_reg <= byte_reg - 3'd1;
        end
        if (cmd.hash_fold) begin
            fold_reg <= fold_next;
        end
        if (cmd.hash_mod) begin
            bkt_reg <= mod_rem[BW-1:0];
        end
        if (cmd.scan) begin
            if (!cur_v && !free_hit_reg) begin
                free_hit_reg <= 1'b1;
                free_reg <= idx_reg;
            end
            if (key_match && better) begin
                hit_reg <= 1'b1;
                sel_reg <= idx_reg;
                sel_bkt_reg <= sbkt_mem[idx_reg];
                sel_rank_reg <= srank_mem[idx_reg];
            end
            idx_reg <= idx_reg + IW'(1);
        end
        if (cmd.commit) begin
            ins_ok_reg <= free_hit_reg;
            unique case (op_reg)
                mptt_pkg::OP_INSERT: if (free_hit_reg) begin
                    sbase_mem[free_reg] <= base_reg;
                    srnd_mem[free_reg]  <= rnd_reg;
                    sbkt_mem[free_reg]  <= bkt_reg;
                end
                mptt_pkg::OP_SET_RND: if (hit_reg) srnd_mem[sel_reg] <= rnd_reg;
                mptt_pkg::OP_SET_BASE: if (hit_reg) sbase_mem[sel_reg] <= base_reg;
                default: ;
            endcase
        end
        // rank fix-up, one slot a cycle; inserted slot gets rank 0
        if (cmd.adjust) begin
            idx_reg <= idx_reg + IW'(1);
            if (op_reg == mptt_pkg::OP_INSERT && ins_ok_reg) begin
                if (idx_reg == free_reg) srank_mem[idx_reg] <= '0;
                else if (valid_reg[idx_reg] && sbkt_mem[idx_reg] == bkt_reg)
                    srank_mem[idx_reg] <= srank_mem[idx_reg] + RW'(1);
            end else if (op_reg == mptt_pkg::OP_DEL_RND && hit_reg) begin
                if (valid_reg[idx_reg] && sbkt_mem[idx_reg] == bkt_reg &&
                    srank_mem[idx_reg] > sel_rank_reg)
                    srank_mem[idx_reg] <= srank_mem[idx_reg] - RW'(1);
            end
        end
    end

    // result selection
    always_comb begin
        res_status = mptt_pkg::ST_MISS;
        res_base = base_reg;
        res_rnd = rnd_reg;
        unique case (op_reg)
            mptt_pkg::OP_INSERT:
                res_status = ins_ok_reg ? mptt_pkg::ST_OK : mptt_pkg::ST_FULL;
            mptt_pkg::OP_CLEAR:
                res_status = mptt_pkg::ST_OK;
            mptt_pkg::OP_NONE: ;
            default: if (hit_reg) begin
                res_status = mptt_pkg::ST_OK;
                res_base = (op_reg == mptt_pkg::OP_DEL_RND) ? sbase_mem[sel_reg] :
                           (op_reg == mptt_pkg::OP_SET_BASE) ? base_reg : sbase_mem[sel_reg];
                res_rnd = (op_reg == mptt_pkg::OP_SET_RND) ? rnd_reg : srnd_mem[sel_reg];
            end
        endcase
    end
endmodule
`default_nettype wire

@@ hw/rtl/mac_pair_translation_table_top.sv @@
// an input transaction passes through hash, fold, bucket reduce, slot scan, update,
// rank fix-up and result load before its result is registered
// no new transaction is taken until both slot scans of the last one are done and its result loads
// the result register frees the controller; a result still waiting at the next load stalls it
// reset: synchronous active-low aresetn empties the table and idles the controller
`default_nettype none
`include "assert_macros.svh"
module mac_pair_translation_table_top (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [103:0] s_tdata,  // operation[2:0], base_addr[50:3], rnd_addr[98:51]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [103:0]      m_tdata   // status[1:0], found_base[49:2], found_rnd[97:50]
);
    mptt_pkg::cmd_t cmd;
    mptt_pkg::sts_t sts;
    logic idle, in_fire, out_busy;
    logic [1:0] res_status;
    logic [47:0] res_base, res_rnd;
    logic [103:0] out_reg;
    logic out_v_reg;

    assign s_tready = idle;
    assign in_fire = s_tvalid && s_tready;
    assign out_busy = out_v_reg && !m_tready;

    mptt_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire), .out_busy(out_busy),
        .sts(sts), .cmd(cmd), .idle(idle)
    );

    mptt_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd),
        .in_op(s_tdata[2:0]), .in_base(s_tdata[50:3]), .in_rnd(s_tdata[98:51]),
        .sts(sts), .res_status(res_status), .res_base(res_base), .res_rnd(res_rnd)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else begin
            if (cmd.finish) out_v_reg <= 1'b1;
            else if (m_tready) out_v_reg <= 1'b0;
        end
    end
    always_ff @(posedge aclk) begin
        if (cmd.finish) out_reg <= {6'd0, res_rnd, res_base, res_status};
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata = out_reg;

    `ASSERT_IMPL(a_no_accept_busy, aclk, aresetn, !idle, !in_fire, "accept while busy")
    `ASSERT_NEXT(a_finish_valid, aclk, aresetn, cmd.finish, m_tvalid, "result lost")
    `ASSERT_IMPL(a_status_range, aclk, aresetn, m_tvalid, m_tdata[1:0] != 2'd3, "bad status")
endmodule
`default_nettype wire
